>>> rtl/core/assert_macros.svh
// Assertion macros shared by the patch evaluator RTL.
// Needs signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define BBPE_CHECK(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("patch evaluator check failed");

// Checked at every edge, reset included.
`define BBPE_CHECK_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("patch evaluator reset check failed");

`endif

>>> rtl/core/bbpe_pkg.sv
// Shared types, widths, codes and index tables of the patch evaluator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbpe_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC        = 15;
   localparam int PARAM_W     = 16;
   localparam int COORD_FRAC  = 16;
   localparam int NUM_POINTS  = 16;
   localparam int NUM_EDGE    = 12;

   localparam int ONE   = 1 << FRAC;
   localparam int RND   = 1 << (FRAC - 1);
   localparam int TW    = FRAC + 1;
   localparam int BW    = TW + 1;
   localparam int DW    = TW + 4;
   localparam int WW    = DW + BW + 1;
   localparam int PW    = COORD_WIDTH + WW;
   localparam int AW    = PW + 4;
   localparam int SW    = AW - 2 * FRAC;
   localparam int HALF  = SW / 2;
   localparam int OUT_W = 64;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_POS    = 2'd1;
   localparam logic [1:0] KIND_NORM   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic RES_POS  = 1'b0;
   localparam logic RES_NORM = 1'b1;

   typedef enum logic [1:0] {OP_LOAD, OP_POS, OP_NORM} op_type;

   typedef logic [3:0] idx_type;
   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   // Grid position (row over v, column over u) to control point slot.
   localparam idx_type GRID_IDX [4][4] = '{
      '{4'd0, 4'd11, 4'd10, 4'd3},
      '{4'd4, 4'd12, 4'd15, 4'd9},
      '{4'd5, 4'd13, 4'd14, 4'd8},
      '{4'd1, 4'd6,  4'd7,  4'd2}
   };

   // Interior slot, first tangent, second tangent, corner.
   localparam idx_type INNER_SRC [4][4] = '{
      '{4'd12, 4'd11, 4'd4,  4'd0},
      '{4'd13, 4'd5,  4'd6,  4'd1},
      '{4'd14, 4'd7,  4'd8,  4'd2},
      '{4'd15, 4'd9,  4'd10, 4'd3}
   };

   typedef struct packed {
      idx_type   index;
      coord_type x;
      coord_type y;
      coord_type z;
   } load_type;

   typedef struct packed {
      logic     en;
      load_type data;
   } write_type;

   typedef struct packed {
      logic [3:0][BW-1:0] b;
      logic [3:0][DW-1:0] d;
   } basis_type;

endpackage

`default_nettype wire

>>> rtl/core/bicubic_bezier_patch_eval_core.sv
// Top level of the bicubic Bezier patch evaluator: request decode, weights,
// control point products and adder tree. Uses bbpe_pkg and the bbpe_* units.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel    Direction  Handshake          Carries
// req_*      in         req_valid/stall    load point or evaluate (u,v)
// rsp_*      out        rsp_valid/stall    position or normal, 64 bits per axis
//
// An evaluate request raises rsp_valid as it leaves the ten-stage pipeline;
// one request can be accepted in every cycle while no stalled response freezes the pipeline.
// A load reaches the control point store as it leaves stage three,
// in request order with respect to evaluations around it.
// Loads and ignored requests produce no response.
// Reset is synchronous and clears the pipeline and all control points.
// A stalled response freezes the whole pipeline; req_stall rises with it.

module bicubic_bezier_patch_eval_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_kind,
   input  wire logic [3:0]          req_point_index,
   input  wire logic signed [31:0]  req_coord_x,
   input  wire logic signed [31:0]  req_coord_y,
   input  wire logic signed [31:0]  req_coord_z,
   input  wire logic [15:0]         req_param_u,
   input  wire logic [15:0]         req_param_v,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_result_kind,
   output logic signed [63:0]       rsp_result_x,
   output logic signed [63:0]       rsp_result_y,
   output logic signed [63:0]       rsp_result_z
);

   localparam int CW   = bbpe_pkg::COORD_WIDTH;
   localparam int FRAC = bbpe_pkg::FRAC;
   localparam int DW   = bbpe_pkg::DW;
   localparam int WW   = bbpe_pkg::WW;
   localparam int PW   = bbpe_pkg::PW;
   localparam int AW   = bbpe_pkg::AW;
   localparam int SW   = bbpe_pkg::SW;

   // The whole pipeline moves together unless a finished response waits.
   logic adv;
   logic take;
   logic keep;
   bbpe_pkg::op_type op_in;

   logic [6:0]            vld_ff;
   logic [6:0]            vld_in;
   bbpe_pkg::op_type      op_ff [7];
   bbpe_pkg::load_type    ld_ff [3];
   bbpe_pkg::write_type   wr;
   bbpe_pkg::coord_type   pts [3][bbpe_pkg::NUM_POINTS];
   bbpe_pkg::basis_type   basis_u, basis_v;

   logic signed [DW-1:0]  sel_a [4];
   logic signed [WW-1:0]  wa_ff [4][4];
   logic signed [WW-1:0]  wb_ff [4][4];
   logic signed [PW-1:0]  pa_ff [3][4][4];
   logic signed [PW-1:0]  pb_ff [3][4][4];
   logic signed [AW-1:0]  sa_ff [3][4];
   logic signed [AW-1:0]  sb_ff [3][4];
   logic signed [AW-1:0]  ta_ff [3];
   logic signed [AW-1:0]  tb_ff [3];
   logic signed [AW-1:0]  ra [3];
   logic signed [AW-1:0]  rb [3];
   logic signed [SW-1:0]  s_ff [3];
   logic signed [SW-1:0]  t_ff [3];
   logic signed [SW-1:0]  s_in [3];
   logic signed [63:0]    res [3];

   function automatic bbpe_pkg::coord_type sat_c(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi;
      logic signed [SW-1:0] lo;
      hi = SW'({1'b0, {(CW-1){1'b1}}});
      lo = -hi - SW'(1);
      if (v > hi) begin
         return hi[CW-1:0];
      end else if (v < lo) begin
         return lo[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // Decode: loads beyond the edge tangents and the unused kind drop out.
   always_comb begin
      op_in = bbpe_pkg::OP_LOAD;
      keep  = 1'b0;
      unique case (req_kind)
         bbpe_pkg::KIND_LOAD: begin
            op_in = bbpe_pkg::OP_LOAD;
            keep  = req_point_index < 4'(bbpe_pkg::NUM_EDGE);
         end
         bbpe_pkg::KIND_POS: begin
            op_in = bbpe_pkg::OP_POS;
            keep  = 1'b1;
         end
         bbpe_pkg::KIND_NORM: begin
            op_in = bbpe_pkg::OP_NORM;
            keep  = 1'b1;
         end
         default: begin
            op_in = bbpe_pkg::OP_LOAD;
            keep  = 1'b0;
         end
      endcase
      take = req_valid && keep;
   end

   // Loads leave the pipeline once they have written the store.
   always_comb begin
      vld_in    = {vld_ff[5:0], take};
      vld_in[3] = vld_ff[2] && (op_ff[2] != bbpe_pkg::OP_LOAD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff[0] <= op_in;
         for (int k = 1; k < 7; k++) begin
            op_ff[k] <= op_ff[k-1];
         end
         ld_ff[0] <= '{index: req_point_index, x: req_coord_x,
                       y: req_coord_y, z: req_coord_z};
         ld_ff[1] <= ld_ff[0];
         ld_ff[2] <= ld_ff[1];
      end
   end

   bbpe_basis u_basis_u (
      .clock (clock),
      .adv   (adv),
      .t_raw (req_param_u),
      .basis (basis_u)
   );

   bbpe_basis u_basis_v (
      .clock (clock),
      .adv   (adv),
      .t_raw (req_param_v),
      .basis (basis_v)
   );

   // A load commits as it leaves stage three; an evaluation ahead of it has
   // already read the store and one behind it reads it after, so ordering is kept.
   assign wr = '{en: adv && vld_ff[2] && (op_ff[2] == bbpe_pkg::OP_LOAD),
                 data: ld_ff[2]};

   bbpe_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .pts   (pts)
   );

   // Stage three: weight grids. Set A is Bu*Bv for a position and Du*Bv
   // for a normal; set B is Bu*Dv.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (op_ff[1] == bbpe_pkg::OP_NORM) begin
            sel_a[i] = $signed(basis_u.d[i]);
         end else begin
            sel_a[i] = $signed(DW'(basis_u.b[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 4; i++) begin
               wa_ff[j][i] <= sel_a[i] * $signed({1'b0, basis_v.b[j]});
               wb_ff[j][i] <= $signed({1'b0, basis_u.b[i]})
                              * $signed(basis_v.d[j]);
            end
         end
      end
   end

   // Stage four: one product per control point, axis and weight set.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            for (int j = 0; j < 4; j++) begin
               for (int i = 0; i < 4; i++) begin
                  pa_ff[a][j][i] <= pts[a][bbpe_pkg::GRID_IDX[j][i]] * wa_ff[j][i];
                  pb_ff[a][j][i] <= pts[a][bbpe_pkg::GRID_IDX[j][i]] * wb_ff[j][i];
               end
            end
         end
      end
   end

   // Stages five and six: a two-level adder tree, four terms per level.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            for (int j = 0; j < 4; j++) begin
               sa_ff[a][j] <= AW'(pa_ff[a][j][0]) + AW'(pa_ff[a][j][1])
                              + AW'(pa_ff[a][j][2]) + AW'(pa_ff[a][j][3]);
               sb_ff[a][j] <= AW'(pb_ff[a][j][0]) + AW'(pb_ff[a][j][1])
                              + AW'(pb_ff[a][j][2]) + AW'(pb_ff[a][j][3]);
            end
            ta_ff[a] <= sa_ff[a][0] + sa_ff[a][1] + sa_ff[a][2] + sa_ff[a][3];
            tb_ff[a] <= sb_ff[a][0] + sb_ff[a][1] + sb_ff[a][2] + sb_ff[a][3];
         end
      end
   end

   // Stage seven: drop the weight fraction with round-half-up. A position
   // is saturated to the coordinate width here and sign extended.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         ra[a] = ta_ff[a] + AW'(1 << (2 * FRAC - 1));
         rb[a] = tb_ff[a] + AW'(1 << (2 * FRAC - 1));
         if (op_ff[5] == bbpe_pkg::OP_NORM) begin
            s_in[a] = ra[a][AW-1:2*FRAC];
         end else begin
            s_in[a] = SW'(sat_c(ra[a][AW-1:2*FRAC]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            s_ff[a] <= s_in[a];
            t_ff[a] <= rb[a][AW-1:2*FRAC];
         end
      end
   end

   bbpe_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld_ff[6]),
      .in_kind   (op_ff[6] == bbpe_pkg::OP_NORM),
      .s_vec     (s_ff),
      .t_vec     (t_ff),
      .out_valid (rsp_valid),
      .out_kind  (rsp_result_kind),
      .out_res   (res)
   );

   assign rsp_result_x = res[0];
   assign rsp_result_y = res[1];
   assign rsp_result_z = res[2];

   `BBPE_CHECK(a_stall_from_output, req_stall |-> (rsp_valid && rsp_stall))
   `BBPE_CHECK(a_pipe_frozen, req_stall |=> $stable(vld_ff))
   `BBPE_CHECK(a_pos_in_range, (rsp_valid && rsp_result_kind == bbpe_pkg::RES_POS) |-> (rsp_result_x[63:31] == '0 || rsp_result_x[63:31] == '1))
   `BBPE_CHECK_ALWAYS(a_reset_empties, reset |=> !rsp_valid)

endmodule

`default_nettype wire

>>> rtl/core/bbpe_basis.sv
// Two-stage Bernstein basis and derivative generator for one parameter.
// Uses bbpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbpe_basis (
   input  wire logic                          clock,
   input  wire logic                          adv,
   input  wire logic [bbpe_pkg::PARAM_W-1:0]  t_raw,
   output bbpe_pkg::basis_type                basis
);

   localparam int TW   = bbpe_pkg::TW;
   localparam int BW   = bbpe_pkg::BW;
   localparam int DW   = bbpe_pkg::DW;
   localparam int FRAC = bbpe_pkg::FRAC;

   logic [TW-1:0]     tc;
   logic [TW-1:0]     sc;
   logic [2*TW-1:0]   tt_sum;
   logic [2*TW-1:0]   ss_sum;
   logic [TW-1:0]     t_ff, s_ff, t2_ff, s2_ff;
   logic [2*TW-1:0]   e0, e3, ts, t2s;
   logic [2*TW+1:0]   e1, e2;
   bbpe_pkg::basis_type basis_in, basis_ff;

   // Stage one: clamp, complement and squares.
   always_comb begin
      if (t_raw > bbpe_pkg::PARAM_W'(bbpe_pkg::ONE)) begin
         tc = TW'(bbpe_pkg::ONE);
      end else begin
         tc = t_raw[TW-1:0];
      end
      sc     = TW'(bbpe_pkg::ONE) - tc;
      tt_sum = tc * tc + (2*TW)'(bbpe_pkg::RND);
      ss_sum = sc * sc + (2*TW)'(bbpe_pkg::RND);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff  <= tc;
         s_ff  <= sc;
         t2_ff <= tt_sum[FRAC+TW-1:FRAC];
         s2_ff <= ss_sum[FRAC+TW-1:FRAC];
      end
   end

   // Stage two: cubic weights and their derivatives.
   always_comb begin
      ts  = t_ff * s2_ff;
      t2s = t2_ff * s_ff;
      e0  = s2_ff * s_ff + (2*TW)'(bbpe_pkg::RND);
      e3  = t2_ff * t_ff + (2*TW)'(bbpe_pkg::RND);
      e1  = {1'b0, ts, 1'b0} + {2'b00, ts} + (2*TW+2)'(bbpe_pkg::RND);
      e2  = {1'b0, t2s, 1'b0} + {2'b00, t2s} + (2*TW+2)'(bbpe_pkg::RND);
      basis_in.b[0] = e0[FRAC+BW-2:FRAC-1] >> 1;
      basis_in.b[1] = e1[FRAC+BW-1:FRAC];
      basis_in.b[2] = e2[FRAC+BW-1:FRAC];
      basis_in.b[3] = e3[FRAC+BW-2:FRAC-1] >> 1;
      basis_in.d[0] = DW'(0) - DW'(3) * DW'(s2_ff);
      basis_in.d[1] = DW'(9) * DW'(t2_ff) + DW'(3 * bbpe_pkg::ONE)
                      - DW'(12) * DW'(t_ff);
      basis_in.d[2] = DW'(6) * DW'(t_ff) - DW'(9) * DW'(t2_ff);
      basis_in.d[3] = DW'(3) * DW'(t2_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         basis_ff <= basis_in;
      end
   end

   assign basis = basis_ff;

endmodule

`default_nettype wire

>>> rtl/core/bbpe_ctrl.sv
// Control point store: 16 points per axis, with interior points rebuilt
// on every write. Uses bbpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbpe_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bbpe_pkg::write_type  wr,
   output bbpe_pkg::coord_type       pts [3][bbpe_pkg::NUM_POINTS]
);

   localparam int CW = bbpe_pkg::COORD_WIDTH;

   bbpe_pkg::coord_type pts_ff [3][bbpe_pkg::NUM_POINTS];
   bbpe_pkg::coord_type pts_in [3][bbpe_pkg::NUM_POINTS];
   logic signed [CW+1:0] mix;

   function automatic bbpe_pkg::coord_type sat_c(input logic signed [CW+1:0] v);
      logic signed [CW+1:0] hi;
      logic signed [CW+1:0] lo;
      hi = (CW+2)'({1'b0, {(CW-1){1'b1}}});
      lo = -hi - (CW+2)'(1);
      if (v > hi) begin
         return hi[CW-1:0];
      end else if (v < lo) begin
         return lo[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

   always_comb begin
      pts_in = pts_ff;
      mix    = '0;
      if (wr.en) begin
         pts_in[0][wr.data.index] = wr.data.x;
         pts_in[1][wr.data.index] = wr.data.y;
         pts_in[2][wr.data.index] = wr.data.z;
         // Each interior is its two neighboring tangents less its corner.
         for (int k = 0; k < 4; k++) begin
            for (int a = 0; a < 3; a++) begin
               mix = (CW+2)'(pts_in[a][bbpe_pkg::INNER_SRC[k][1]])
                     + (CW+2)'(pts_in[a][bbpe_pkg::INNER_SRC[k][2]])
                     - (CW+2)'(pts_in[a][bbpe_pkg::INNER_SRC[k][3]]);
               pts_in[a][bbpe_pkg::INNER_SRC[k][0]] = sat_c(mix);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            for (int i = 0; i < bbpe_pkg::NUM_POINTS; i++) begin
               pts_ff[a][i] <= '0;
            end
         end
      end else begin
         pts_ff <= pts_in;
      end
   end

   assign pts = pts_ff;

endmodule

`default_nettype wire

>>> rtl/core/bbpe_cross.sv
// Three-stage cross product of the two surface tangents with the result
// register; position results pass alongside. Uses bbpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbpe_cross (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            adv,
   input  wire logic                            in_valid,
   input  wire logic                            in_kind,
   input  wire logic signed [bbpe_pkg::SW-1:0]  s_vec [3],
   input  wire logic signed [bbpe_pkg::SW-1:0]  t_vec [3],
   output logic                                 out_valid,
   output logic                                 out_kind,
   output logic signed [bbpe_pkg::OUT_W-1:0]    out_res [3]
);

   localparam int SW   = bbpe_pkg::SW;
   localparam int HALF = bbpe_pkg::HALF;
   localparam int LW   = SW + HALF + 1;
   localparam int HW   = 2 * SW - HALF;
   localparam int FW   = 2 * SW;
   localparam int CF   = bbpe_pkg::COORD_FRAC;
   localparam int OW   = bbpe_pkg::OUT_W;
   localparam int QW   = FW + 1 - CF;
   localparam int PB [3] = '{1, 2, 0};
   localparam int PC [3] = '{2, 0, 1};

   logic [1:0]               vld_ff;
   logic [1:0]               kind_ff;
   logic signed [SW-1:0]     pass_ff [2][3];
   logic signed [LW-1:0]     plo_ff [6];
   logic signed [HW-1:0]     phi_ff [6];
   logic signed [FW-1:0]     full_ff [6];
   logic signed [FW:0]       diff [3];
   logic signed [QW-1:0]     quot [3];
   logic signed [OW-1:0]     res_in [3];
   logic signed [OW-1:0]     res_ff [3];
   logic                     out_valid_ff;
   logic                     out_kind_ff;

   function automatic logic signed [OW-1:0] sat_o(input logic signed [QW-1:0] v);
      logic signed [QW-1:0] hi;
      logic signed [QW-1:0] lo;
      hi = QW'({1'b0, {(OW-1){1'b1}}});
      lo = -hi - QW'(1);
      if (v > hi) begin
         return hi[OW-1:0];
      end else if (v < lo) begin
         return lo[OW-1:0];
      end
      return v[OW-1:0];
   endfunction

   // The tangent factor is split in halves so each multiply stays narrow.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            plo_ff[2*a]   <= s_vec[PB[a]] * $signed({1'b0, t_vec[PC[a]][HALF-1:0]});
            phi_ff[2*a]   <= s_vec[PB[a]] * $signed(t_vec[PC[a]][SW-1:HALF]);
            plo_ff[2*a+1] <= s_vec[PC[a]] * $signed({1'b0, t_vec[PB[a]][HALF-1:0]});
            phi_ff[2*a+1] <= s_vec[PC[a]] * $signed(t_vec[PB[a]][SW-1:HALF]);
            pass_ff[0][a] <= s_vec[a];
            pass_ff[1][a] <= pass_ff[0][a];
         end
         for (int p = 0; p < 6; p++) begin
            full_ff[p] <= (FW'(phi_ff[p]) <<< HALF) + FW'(plo_ff[p]);
         end
         kind_ff <= {kind_ff[0], in_kind};
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff[a] = (FW+1)'(full_ff[2*a]) - (FW+1)'(full_ff[2*a+1])
                   + (FW+1)'(1 << (CF - 1));
         quot[a] = diff[a][FW:CF];
         if (kind_ff[1] == bbpe_pkg::RES_NORM) begin
            res_in[a] = sat_o(quot[a]);
         end else begin
            res_in[a] = OW'(pass_ff[1][a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[0], in_valid};
         out_valid_ff <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_kind_ff <= kind_ff[1];
         res_ff      <= res_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_kind  = out_kind_ff;
   assign out_res   = res_ff;

endmodule

`default_nettype wire
